### rtl/irpw_pkg.sv
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and constants of the infrared pulse-width decoder.
// ----------------------------------------------------------------------------
package irpw_pkg;

	// code length and field widths
	localparam int CODE_BITS  = 12;
	localparam int IDX_W      = 4;
	localparam int TICK_W     = 16;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CODE_BITS-1:0] CODE_TOP = CODE_BITS'(1) << (CODE_BITS - 1);
	localparam logic [TICK_W-1:0]    TICK_MAX = '1;

	// register reset values
	localparam logic [THR_W-1:0]  RST_BIT_THRESHOLD = 8'd40;
	localparam logic [THR_W-1:0]  RST_PHASE_TIMEOUT = 8'd200;
	localparam logic [TICK_W-1:0] RST_START_TIMEOUT = 16'd2000;

	// input operation codes
	localparam logic OP_ARM  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIT_THRESHOLD = 2'd0,
		CFG_PHASE_TIMEOUT = 2'd1,
		CFG_START_TIMEOUT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_LOW   = 2'd2,
		PH_HIGH  = 2'd3
	} phase_t;

endpackage

### rtl/irpw_ifs.sv
// ----------------------------------------------------------------------------
// irpw_ifs
// Valid/ready channels of the decoder: samples, results and register writes.
// ----------------------------------------------------------------------------
interface irpw_sample_if;
	import irpw_pkg::*;
	logic valid;
	logic ready;
	logic operation;
	logic line_level;

	modport source (output valid, output operation, output line_level, input ready);
	modport sink (input valid, input operation, input line_level, output ready);
endinterface

interface irpw_result_if;
	import irpw_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 received_ok;
	logic [CODE_BITS-1:0] code;

	modport source (output valid, output received_ok, output code, input ready);
	modport sink (input valid, input received_ok, input code, output ready);
endinterface

interface irpw_cfg_if;
	import irpw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/ir_pulse_width_decoder_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder_top
// A result reaches the result channel through the input register and the
// output register after the transfer of the sample that ends the reception.
// Throughput: one sample or arm item per cycle; the input register stalls
// only while a result waits in the full output register.
// Reset: arst_n clears phase to idle, counters and code, loads default registers.
// ----------------------------------------------------------------------------
module ir_pulse_width_decoder_top (
	input  logic          clk,
	input  logic          arst_n,
	irpw_sample_if.sink   sample,
	irpw_result_if.source result,
	irpw_cfg_if.sink      cfg
);
	import irpw_pkg::*;

	// configuration registers
	logic [THR_W-1:0]  bit_threshold_q;
	logic [THR_W-1:0]  phase_timeout_q;
	logic [TICK_W-1:0] start_timeout_q;

	// input register
	logic valid_s1;
	logic operation_s1;
	logic line_level_s1;

	// decoder state
	phase_t               phase_q, phase_d;
	logic [TICK_W-1:0]    tick_q, tick_d;
	logic [IDX_W-1:0]     bit_idx_q, bit_idx_d;
	logic [CODE_BITS-1:0] code_q, code_d;

	// output register
	logic                 out_valid_q;
	logic                 out_ok_q;
	logic [CODE_BITS-1:0] out_code_q;

	logic                 res;
	logic                 res_ok;
	logic                 out_free;
	logic                 go;
	logic [TICK_W-1:0]    tick_inc;
	logic [CODE_BITS-1:0] code_set;
	logic [TICK_W-1:0]    thr_ext;
	logic [TICK_W-1:0]    ptmo_ext;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_threshold_q <= RST_BIT_THRESHOLD;
			phase_timeout_q <= RST_PHASE_TIMEOUT;
			start_timeout_q <= RST_START_TIMEOUT;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BIT_THRESHOLD: bit_threshold_q <= cfg.data[THR_W-1:0];
				CFG_PHASE_TIMEOUT: phase_timeout_q <= cfg.data[THR_W-1:0];
				CFG_START_TIMEOUT: start_timeout_q <= cfg.data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// the output slot is free when empty or being drained this cycle
	assign out_free     = !out_valid_q || result.ready;
	assign go           = valid_s1 && (!res || out_free);
	assign sample.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready) begin
			operation_s1  <= sample.operation;
			line_level_s1 <= sample.line_level;
		end
	end

	assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;
	assign code_set = code_q | (CODE_TOP >> bit_idx_q);
	assign thr_ext  = {{(TICK_W-THR_W){1'b0}}, bit_threshold_q};
	assign ptmo_ext = {{(TICK_W-THR_W){1'b0}}, phase_timeout_q};

	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		bit_idx_d = bit_idx_q;
		code_d    = code_q;
		res       = 1'b0;
		res_ok    = 1'b0;
		if (operation_s1 == OP_ARM) begin
			phase_d   = PH_START;
			tick_d    = '0;
			bit_idx_d = '0;
			code_d    = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_START: begin
					if (!line_level_s1) begin
						bit_idx_d = '0;
						phase_d   = PH_LOW;
						tick_d    = TICK_W'(1);
						if (phase_timeout_q == '0) begin
							res     = 1'b1;
							phase_d = PH_IDLE;
						end
					end else begin
						tick_d = tick_inc;
						if (tick_inc > start_timeout_q) begin
							res     = 1'b1;
							phase_d = PH_IDLE;
						end
					end
				end
				PH_LOW: begin
					if (line_level_s1) begin
						// low pulse over: longer than threshold decodes as one
						if (tick_q > thr_ext) begin
							code_d = code_set;
						end
						if (bit_idx_q >= IDX_W'(CODE_BITS - 1)) begin
							res     = 1'b1;
							res_ok  = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_HIGH;
							tick_d  = TICK_W'(1);
							if (phase_timeout_q == '0) begin
								res     = 1'b1;
								phase_d = PH_IDLE;
							end
						end
					end else begin
						tick_d = tick_inc;
						if (tick_inc > ptmo_ext) begin
							res     = 1'b1;
							phase_d = PH_IDLE;
						end
					end
				end
				PH_HIGH: begin
					if (!line_level_s1) begin
						bit_idx_d = bit_idx_q + 1'b1;
						phase_d   = PH_LOW;
						tick_d    = TICK_W'(1);
						if (phase_timeout_q == '0) begin
							res     = 1'b1;
							phase_d = PH_IDLE;
						end
					end else begin
						tick_d = tick_inc;
						if (tick_inc > ptmo_ext) begin
							res     = 1'b1;
							phase_d = PH_IDLE;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bit_idx_q <= '0;
			code_q    <= '0;
		end else if (go) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			bit_idx_q <= bit_idx_d;
			code_q    <= code_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && res) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res) begin
			out_ok_q   <= res_ok;
			out_code_q <= code_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.received_ok = out_ok_q;
	assign result.code        = out_code_q;

endmodule

### rtl/irpw_checker.sv
// ----------------------------------------------------------------------------
// irpw_checker
// Port-level checks of the decoder top level, attached by bind.
// ----------------------------------------------------------------------------
module irpw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           sample_valid,
	input logic                           sample_ready,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic                           result_received_ok,
	input logic [irpw_pkg::CODE_BITS-1:0] result_code
);
	import irpw_pkg::*;

	// a stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_received_ok) && $stable(result_code))
		else $error("result changed while stalled");

	// samples are only held off by a waiting result
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("sample channel stalled with empty output");

	// a fresh result comes from an earlier sample transfer, via the input and output registers
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
		else $error("result without a matching sample transfer");

endmodule

bind ir_pulse_width_decoder_top irpw_checker u_irpw_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.sample_valid       (sample.valid),
	.sample_ready       (sample.ready),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.result_received_ok (result.received_ok),
	.result_code        (result.code)
);
